// File: hdl/tpta_pkg.sv
// Package with the item types, operation codes and defaults of the transmit throttle arbiter.
package tpta_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned NUM_CLASSES = 4;

    localparam logic [15:0] THROTTLE_MS_RST = 16'd50;
    localparam logic [15:0] READ_GUARANTEE_MS_RST = 16'd200;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THROTTLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_READ_GUARANTEE = 8'd1;

    localparam logic [1:0] FUNC_PUMP = 2'd0;
    localparam logic [1:0] FUNC_ENQUEUE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR_ALL = 2'd2;
    localparam logic [1:0] FUNC_CLEAR_MOVE = 2'd3;

    localparam logic [1:0] CLASS_ESTOP = 2'd0;
    localparam logic [1:0] CLASS_READ = 2'd1;
    localparam logic [1:0] CLASS_MOVE = 2'd2;
    localparam logic [1:0] CLASS_OTHER = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  queue_class;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic       sent;
        logic [1:0] sent_class;
        logic       enqueue_rejected;
    } out_item_t;

endpackage

// File: hdl/tx_priority_throttle_arbiter.sv
// Top level of the transmit scheduler: four class counters, send throttle and read guarantee.
// An item offered at the input enters the input register when it is accepted, and its result
// enters the result register when that register is empty or being drained by the sink.
// Throughput is one item per cycle while the sink takes results; the counters and send times
// update in the same cycle the result register loads, so the next item sees them at once.
// Reset (aresetn low, synchronous) empties all counters, zeroes both send times, restores the
// register defaults and drops both pipeline stages; the configuration port is always ready.
module tx_priority_throttle_arbiter #(
    parameter int unsigned QUEUE_DEPTH = tpta_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tpta_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tpta_pkg::out_item_t                m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tpta_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpta_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic [15:0] throttle_reg;
    logic [15:0] read_guarantee_reg;

    logic                 in_valid_reg;
    tpta_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg;
    tpta_pkg::out_item_t  out_item_reg;
    tpta_pkg::out_item_t  out_item_next;

    logic [CNT_W-1:0] count_reg [tpta_pkg::NUM_CLASSES];
    logic [CNT_W-1:0] count_next [tpta_pkg::NUM_CLASSES];
    logic [31:0]      last_send_reg;
    logic [31:0]      last_send_next;
    logic [31:0]      last_read_reg;
    logic [31:0]      last_read_next;

    logic                         advance;
    logic [tpta_pkg::NUM_CLASSES-1:0] nonempty;
    logic [tpta_pkg::NUM_CLASSES-1:0] full;
    logic [31:0]                  since_send;
    logic [31:0]                  since_read;
    logic                         throttled;
    logic                         read_due;
    logic                         do_send;
    logic [1:0]                   pick;
    logic                         reject;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            throttle_reg       <= tpta_pkg::THROTTLE_MS_RST;
            read_guarantee_reg <= tpta_pkg::READ_GUARANTEE_MS_RST;
        end else if (cfg_valid) begin
            if (cfg_index == tpta_pkg::CFG_IDX_THROTTLE) begin
                throttle_reg <= cfg_data[15:0];
            end else if (cfg_index == tpta_pkg::CFG_IDX_READ_GUARANTEE) begin
                read_guarantee_reg <= cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    always_comb begin
        for (int i = 0; i < tpta_pkg::NUM_CLASSES; i++) begin
            nonempty[i] = count_reg[i] != '0;
            full[i]     = count_reg[i] == CNT_FULL;
        end
        since_send = in_item_reg.now_ms - last_send_reg;
        since_read = in_item_reg.now_ms - last_read_reg;
        throttled  = (last_send_reg != '0) && (since_send < {16'd0, throttle_reg});
        read_due   = nonempty[tpta_pkg::CLASS_READ] &&
                     ((last_read_reg == '0) || (since_read >= {16'd0, read_guarantee_reg}));
        do_send    = (in_item_reg.func == tpta_pkg::FUNC_PUMP) && (|nonempty) && !throttled;

        if (nonempty[tpta_pkg::CLASS_ESTOP]) begin
            pick = tpta_pkg::CLASS_ESTOP;
        end else if (read_due) begin
            pick = tpta_pkg::CLASS_READ;
        end else if (nonempty[tpta_pkg::CLASS_MOVE]) begin
            pick = tpta_pkg::CLASS_MOVE;
        end else if (nonempty[tpta_pkg::CLASS_READ]) begin
            pick = tpta_pkg::CLASS_READ;
        end else begin
            pick = tpta_pkg::CLASS_OTHER;
        end

        reject = (in_item_reg.func == tpta_pkg::FUNC_ENQUEUE) && full[in_item_reg.queue_class];

        for (int i = 0; i < tpta_pkg::NUM_CLASSES; i++) begin
            count_next[i] = count_reg[i];
            case (in_item_reg.func)
                tpta_pkg::FUNC_PUMP: begin
                    if (do_send && pick == 2'(i)) begin
                        count_next[i] = count_reg[i] - CNT_ONE;
                    end
                end
                tpta_pkg::FUNC_ENQUEUE: begin
                    if (in_item_reg.queue_class == 2'(i) && !full[i]) begin
                        count_next[i] = count_reg[i] + CNT_ONE;
                    end
                end
                tpta_pkg::FUNC_CLEAR_ALL: begin
                    count_next[i] = '0;
                end
                tpta_pkg::FUNC_CLEAR_MOVE: begin
                    if (2'(i) == tpta_pkg::CLASS_MOVE) begin
                        count_next[i] = '0;
                    end
                end
                default: begin
                    count_next[i] = count_reg[i];
                end
            endcase
        end

        last_send_next = do_send ? in_item_reg.now_ms : last_send_reg;
        last_read_next = (do_send && pick == tpta_pkg::CLASS_READ) ?
                         in_item_reg.now_ms : last_read_reg;

        out_item_next.sent             = do_send;
        out_item_next.sent_class       = do_send ? pick : tpta_pkg::CLASS_ESTOP;
        out_item_next.enqueue_rejected = reject;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tpta_pkg::NUM_CLASSES; i++) begin
                count_reg[i] <= '0;
            end
            last_send_reg <= '0;
            last_read_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                for (int i = 0; i < tpta_pkg::NUM_CLASSES; i++) begin
                    count_reg[i] <= count_next[i];
                end
                last_send_reg <= last_send_next;
                last_read_reg <= last_read_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

// File: hdl/tpta_checker.sv
// Port-level checker for the transmit throttle arbiter and its bind statement.
module tpta_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input tpta_pkg::out_item_t m_data
);

    // A result waiting for the sink holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result changed or vanished.");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    // A pump and an enqueue are distinct operations.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.sent && m_data.enqueue_rejected))
        else $error("Result both sent and rejected.");

    // The served class reads as estop when nothing was sent.
    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.sent |-> m_data.sent_class == tpta_pkg::CLASS_ESTOP)
        else $error("Class set without a send.");

endmodule

bind tx_priority_throttle_arbiter tpta_checker u_tpta_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
